[rtl/stereo_gain_bar_meter_hold_defines.svh]
// Assertion macros shared by the stereo gain bar meter hold design
`ifndef STEREO_GAIN_BAR_METER_HOLD_DEFINES_SVH
`define STEREO_GAIN_BAR_METER_HOLD_DEFINES_SVH

// Check that a condition implies another in the same cycle
`define SGBM_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Check that a condition implies another in the next cycle
`define SGBM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

[rtl/sgbm_pkg.sv]
// Types and constants for the stereo gain bar meter hold block
package sgbm_pkg;

    localparam int SEGMENTS  = 11;
    localparam int SAMPLE_W  = 16;
    localparam int GAIN_W    = 10;
    localparam int HOLD_W    = 15;
    localparam int LAMP_W    = 11;
    localparam int VOLT      = 2048;
    localparam int FRAC_W    = 8;
    localparam int PROD_W    = SAMPLE_W + GAIN_W;
    localparam int SCALED_W  = PROD_W - FRAC_W;
    localparam int LIT_W     = (SEGMENTS > LAMP_W) ? SEGMENTS : LAMP_W;
    localparam int ADDR_W    = 4;
    localparam int DATA_W    = 32;

    localparam logic [GAIN_W-1:0] GAIN_RESET     = GAIN_W'(256);
    localparam logic [HOLD_W-1:0] SEG_HOLD_RESET = HOLD_W'(5000);
    localparam logic [HOLD_W-1:0] TOP_HOLD_RESET = HOLD_W'(20000);

    // Register indexes on the configuration port
    typedef enum logic [1:0] {
        REG_GAIN     = 2'd0,
        REG_SEG_HOLD = 2'd1,
        REG_TOP_HOLD = 2'd2
    } reg_idx_t;

    // Hold reload values handed to each meter lane
    typedef struct packed {
        logic [HOLD_W-1:0] segment_hold;
        logic [HOLD_W-1:0] top_hold;
    } hold_cfg_t;

endpackage

[rtl/sgbm_gain_lane.sv]
// One channel gain lane: registered product, floor scaling, saturation, on gating
module sgbm_gain_lane (
    input  logic                                   aclk,
    input  logic                                   load,
    input  logic signed [sgbm_pkg::SAMPLE_W-1:0]   sample,
    input  logic        [sgbm_pkg::GAIN_W-1:0]     gain,
    input  logic                                   on_flag,
    output logic signed [sgbm_pkg::SAMPLE_W-1:0]   value
);

    logic signed [sgbm_pkg::PROD_W-1:0]   product_reg;
    logic signed [sgbm_pkg::PROD_W-1:0]   product_next;
    logic                                 on_reg;
    logic signed [sgbm_pkg::SCALED_W-1:0] scaled;

    // Multiply sample by unsigned gain
    assign product_next = sgbm_pkg::PROD_W'(sample) * $signed({1'b0, gain});

    // Hold the product of the accepted item
    always_ff @(posedge aclk) begin
        if (load) begin
            product_reg <= product_next;
            on_reg      <= on_flag;
        end
    end

    // Drop fraction bits (floor), then saturate and gate
    assign scaled = product_reg[sgbm_pkg::PROD_W-1:sgbm_pkg::FRAC_W];

    always_comb begin
        if (!on_reg) begin
            value = '0;
        end else if (scaled > sgbm_pkg::SCALED_W'(32767)) begin
            value = 16'sh7FFF;
        end else if (scaled < -sgbm_pkg::SCALED_W'(32768)) begin
            value = -16'sh8000;
        end else begin
            value = scaled[sgbm_pkg::SAMPLE_W-1:0];
        end
    end

endmodule

[rtl/sgbm_meter_lane.sv]
// One channel meter lane: per-segment threshold compare and hold counters
module sgbm_meter_lane (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  update,
    input  logic signed [sgbm_pkg::SAMPLE_W-1:0]  value,
    input  sgbm_pkg::hold_cfg_t                   hold_cfg,
    output logic        [sgbm_pkg::LAMP_W-1:0]    lamps
);

    logic [sgbm_pkg::HOLD_W-1:0] count_reg  [sgbm_pkg::SEGMENTS];
    logic [sgbm_pkg::HOLD_W-1:0] count_next [sgbm_pkg::SEGMENTS];
    logic [sgbm_pkg::LIT_W-1:0]  lit;

    // Reload on threshold, light on nonzero, count down
    always_comb begin
        logic [sgbm_pkg::HOLD_W-1:0] loaded;
        logic signed [sgbm_pkg::SAMPLE_W:0] thr;
        lit = '0;
        for (int i = 0; i < sgbm_pkg::SEGMENTS; i++) begin
            thr = (sgbm_pkg::SAMPLE_W+1)'(i * sgbm_pkg::VOLT);
            loaded = count_reg[i];
            if ($signed({value[sgbm_pkg::SAMPLE_W-1], value}) > thr) begin
                loaded = (i == sgbm_pkg::SEGMENTS - 1) ? hold_cfg.top_hold
                                                       : hold_cfg.segment_hold;
            end
            if (loaded != '0) begin
                lit[i]        = 1'b1;
                count_next[i] = loaded - sgbm_pkg::HOLD_W'(1);
            end else begin
                count_next[i] = '0;
            end
        end
    end

    assign lamps = lit[sgbm_pkg::LAMP_W-1:0];

    // Advance counters once per item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < sgbm_pkg::SEGMENTS; i++) begin
                count_reg[i] <= '0;
            end
        end else if (update) begin
            count_reg <= count_next;
        end
    end

endmodule

[rtl/stereo_gain_bar_meter_hold.sv]
// Top level: config registers, on flag, gain and meter lanes, merged output register
// Pipeline: the product register stage, then the meter stage into the output register.
// Throughput: one item per cycle unless stalled; segment counters all update in parallel.
// The product register stage is the only multiplier path; each lane has its own.
// Reset (synchronous, aresetn low): gain 256, segment hold 5000, top hold 20000,
// on flag set, counters cleared, pipeline empty.
`include "stereo_gain_bar_meter_hold_defines.svh"

module stereo_gain_bar_meter_hold (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // configuration port
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [sgbm_pkg::ADDR_W-1:0]          paddr,
    input  logic [sgbm_pkg::DATA_W-1:0]          pwdata,
    output logic [sgbm_pkg::DATA_W-1:0]          prdata,
    output logic                                 pready,
    // input channel
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [sgbm_pkg::SAMPLE_W-1:0] s_left_sample,
    input  logic signed [sgbm_pkg::SAMPLE_W-1:0] s_right_sample,
    input  logic signed [sgbm_pkg::SAMPLE_W-1:0] s_send_one_sample,
    input  logic signed [sgbm_pkg::SAMPLE_W-1:0] s_send_two_sample,
    input  logic                                 s_button_level,
    // result channel
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [sgbm_pkg::SAMPLE_W-1:0] m_left_out,
    output logic signed [sgbm_pkg::SAMPLE_W-1:0] m_right_out,
    output logic signed [sgbm_pkg::SAMPLE_W-1:0] m_send_one_out,
    output logic signed [sgbm_pkg::SAMPLE_W-1:0] m_send_two_out,
    output logic                                 m_on_lamp,
    output logic        [sgbm_pkg::LAMP_W-1:0]   m_left_segments,
    output logic        [sgbm_pkg::LAMP_W-1:0]   m_right_segments
);

    logic [sgbm_pkg::GAIN_W-1:0] gain_reg;
    logic [sgbm_pkg::HOLD_W-1:0] seg_hold_reg;
    logic [sgbm_pkg::HOLD_W-1:0] top_hold_reg;
    sgbm_pkg::reg_idx_t          reg_idx;
    logic                        cfg_write;
    sgbm_pkg::hold_cfg_t         hold_cfg;

    logic on_flag_reg, on_flag_next;
    logic button_prev_reg;
    logic accept, advance, move;

    logic                                 st1_valid_reg, st1_valid_next;
    logic signed [sgbm_pkg::SAMPLE_W-1:0] st1_send_one_reg;
    logic signed [sgbm_pkg::SAMPLE_W-1:0] st1_send_two_reg;
    logic                                 st1_on_reg;

    logic signed [sgbm_pkg::SAMPLE_W-1:0] left_value, right_value;
    logic [sgbm_pkg::LAMP_W-1:0]          left_lamps, right_lamps;

    logic m_valid_reg, m_valid_next;

    // Decode and write configuration registers
    assign pready    = 1'b1;
    assign reg_idx   = sgbm_pkg::reg_idx_t'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg     <= sgbm_pkg::GAIN_RESET;
            seg_hold_reg <= sgbm_pkg::SEG_HOLD_RESET;
            top_hold_reg <= sgbm_pkg::TOP_HOLD_RESET;
        end else if (cfg_write) begin
            case (reg_idx)
                sgbm_pkg::REG_GAIN:     gain_reg     <= pwdata[sgbm_pkg::GAIN_W-1:0];
                sgbm_pkg::REG_SEG_HOLD: seg_hold_reg <= pwdata[sgbm_pkg::HOLD_W-1:0];
                sgbm_pkg::REG_TOP_HOLD: top_hold_reg <= pwdata[sgbm_pkg::HOLD_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        case (reg_idx)
            sgbm_pkg::REG_GAIN:     prdata = sgbm_pkg::DATA_W'(gain_reg);
            sgbm_pkg::REG_SEG_HOLD: prdata = sgbm_pkg::DATA_W'(seg_hold_reg);
            sgbm_pkg::REG_TOP_HOLD: prdata = sgbm_pkg::DATA_W'(top_hold_reg);
            default:                prdata = '0;
        endcase
    end

    assign hold_cfg.segment_hold = seg_hold_reg;
    assign hold_cfg.top_hold     = top_hold_reg;

    // Pipeline flow control
    assign advance = !m_valid_reg || m_ready;
    assign s_ready = !st1_valid_reg || advance;
    assign accept  = s_valid && s_ready;
    assign move    = st1_valid_reg && advance;

    assign st1_valid_next = s_ready ? s_valid : st1_valid_reg;
    assign m_valid_next   = advance ? st1_valid_reg : m_valid_reg;

    // Toggle the on flag on a rising button edge
    assign on_flag_next = (s_button_level && !button_prev_reg) ? !on_flag_reg : on_flag_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            on_flag_reg     <= 1'b1;
            button_prev_reg <= 1'b0;
            st1_valid_reg   <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (accept) begin
                on_flag_reg     <= on_flag_next;
                button_prev_reg <= s_button_level;
            end
            st1_valid_reg <= st1_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Hold stage-one pass-through fields
    always_ff @(posedge aclk) begin
        if (accept) begin
            st1_send_one_reg <= s_send_one_sample;
            st1_send_two_reg <= s_send_two_sample;
            st1_on_reg       <= on_flag_next;
        end
    end

    // Gain lanes
    sgbm_gain_lane u_gain_left (
        .aclk    (aclk),
        .load    (accept),
        .sample  (s_left_sample),
        .gain    (gain_reg),
        .on_flag (on_flag_next),
        .value   (left_value)
    );

    sgbm_gain_lane u_gain_right (
        .aclk    (aclk),
        .load    (accept),
        .sample  (s_right_sample),
        .gain    (gain_reg),
        .on_flag (on_flag_next),
        .value   (right_value)
    );

    // Meter lanes
    sgbm_meter_lane u_meter_left (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .update   (move),
        .value    (left_value),
        .hold_cfg (hold_cfg),
        .lamps    (left_lamps)
    );

    sgbm_meter_lane u_meter_right (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .update   (move),
        .value    (right_value),
        .hold_cfg (hold_cfg),
        .lamps    (right_lamps)
    );

    // Merge lane results into the output register
    always_ff @(posedge aclk) begin
        if (move) begin
            m_left_out       <= left_value;
            m_right_out      <= right_value;
            m_send_one_out   <= st1_send_one_reg;
            m_send_two_out   <= st1_send_two_reg;
            m_on_lamp        <= st1_on_reg;
            m_left_segments  <= left_lamps;
            m_right_segments <= right_lamps;
        end
    end

    assign m_valid = m_valid_reg;

    // Checks
    `SGBM_ASSERT_NEXT(a_accept_fills_stage, accept, st1_valid_reg)
    `SGBM_ASSERT_NEXT(a_move_fills_output, move, m_valid_reg)
    `SGBM_ASSERT_SAME(a_off_is_silent, m_valid_reg && !m_on_lamp,
                      m_left_out == '0 && m_right_out == '0)

endmodule

[verif/tb_stereo_gain_bar_meter_hold.sv]
// Testbench for the stereo gain stage with bar-graph meters and per-segment peak hold
module tb_stereo_gain_bar_meter_hold;
    import sgbm_pkg::*;

    localparam int TICKS_PER_PHASE = 190;
    localparam int NUM_PHASES      = 8;
    localparam int DRAIN_CYCLES    = 6;
    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int LONG_PAUSE      = 80;
    localparam int MAX_PRINTED     = 60;

    // One sample tick as offered on the input channel
    typedef struct {
        logic signed [SAMPLE_W-1:0] left;
        logic signed [SAMPLE_W-1:0] right;
        logic signed [SAMPLE_W-1:0] send_one;
        logic signed [SAMPLE_W-1:0] send_two;
        logic                       button;
    } tick_t;

    // One output frame: scaled samples, sends and lamp states
    typedef struct {
        logic signed [SAMPLE_W-1:0] left_out;
        logic signed [SAMPLE_W-1:0] right_out;
        logic signed [SAMPLE_W-1:0] send_one_out;
        logic signed [SAMPLE_W-1:0] send_two_out;
        logic                       on_lamp;
        logic [LAMP_W-1:0]          left_segs;
        logic [LAMP_W-1:0]          right_segs;
    } lamp_frame_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [ADDR_W-1:0] paddr   = '0;
    logic [DATA_W-1:0] pwdata  = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    logic                       s_valid           = 1'b0;
    logic                       s_ready;
    logic signed [SAMPLE_W-1:0] s_left_sample     = '0;
    logic signed [SAMPLE_W-1:0] s_right_sample    = '0;
    logic signed [SAMPLE_W-1:0] s_send_one_sample = '0;
    logic signed [SAMPLE_W-1:0] s_send_two_sample = '0;
    logic                       s_button_level    = 1'b0;

    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic signed [SAMPLE_W-1:0] m_left_out;
    logic signed [SAMPLE_W-1:0] m_right_out;
    logic signed [SAMPLE_W-1:0] m_send_one_out;
    logic signed [SAMPLE_W-1:0] m_send_two_out;
    logic                       m_on_lamp;
    logic [LAMP_W-1:0]          m_left_segments;
    logic [LAMP_W-1:0]          m_right_segments;

    stereo_gain_bar_meter_hold dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_left_sample    (s_left_sample),
        .s_right_sample   (s_right_sample),
        .s_send_one_sample(s_send_one_sample),
        .s_send_two_sample(s_send_two_sample),
        .s_button_level   (s_button_level),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_left_out       (m_left_out),
        .m_right_out      (m_right_out),
        .m_send_one_out   (m_send_one_out),
        .m_send_two_out   (m_send_two_out),
        .m_on_lamp        (m_on_lamp),
        .m_left_segments  (m_left_segments),
        .m_right_segments (m_right_segments)
    );

    // Free-running clock, period 10
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Shadow of the configuration registers
    logic [GAIN_W-1:0] gain_cfg     = GAIN_RESET;
    logic [HOLD_W-1:0] seg_hold_cfg = SEG_HOLD_RESET;
    logic [HOLD_W-1:0] top_hold_cfg = TOP_HOLD_RESET;

    // Shadow of the block state
    logic              on_flag  = 1'b1;
    logic              btn_prev = 1'b0;
    logic [HOLD_W-1:0] hold_cnt [2][SEGMENTS] = '{default: '0};

    tick_t       pending_ticks [$];
    lamp_frame_t expected_frames [$];
    tick_t       on_wire;

    int err_cnt      = 0;
    int results_done = 0;

    // Multiply by the gain, floor the fraction, saturate, gate with the on flag
    function automatic logic signed [SAMPLE_W-1:0] scale_sample(
        input logic signed [SAMPLE_W-1:0] s
    );
        int prod;
        int q;
        if (!on_flag)
            return '0;
        prod = int'(s) * int'(gain_cfg);
        q = prod >>> FRAC_W;
        if (q > 32767)
            q = 32767;
        if (q < -32768)
            q = -32768;
        return SAMPLE_W'(q);
    endfunction

    // Retrigger segments below the level, then light and count down live ones
    function automatic logic [LAMP_W-1:0] meter_step(input int ch, input int level);
        logic [LIT_W-1:0] lit;
        lit = '0;
        for (int i = 0; i < SEGMENTS; i++) begin
            if (level > i * VOLT)
                hold_cnt[ch][i] = (i == SEGMENTS - 1) ? top_hold_cfg : seg_hold_cfg;
            if (hold_cnt[ch][i] != '0) begin
                hold_cnt[ch][i] = hold_cnt[ch][i] - HOLD_W'(1);
                lit[i] = 1'b1;
            end
        end
        return lit[LAMP_W-1:0];
    endfunction

    // Advance the shadow state by one tick and return the frame it produces
    function automatic lamp_frame_t gain_meter_step(input tick_t t);
        lamp_frame_t f;
        if (t.button && !btn_prev)
            on_flag = !on_flag;
        btn_prev = t.button;
        f.left_out     = scale_sample(t.left);
        f.right_out    = scale_sample(t.right);
        f.send_one_out = t.send_one;
        f.send_two_out = t.send_two;
        f.on_lamp      = on_flag;
        f.left_segs    = meter_step(0, int'(f.left_out));
        f.right_segs   = meter_step(1, int'(f.right_out));
        return f;
    endfunction

    // Print one mismatch line (capped) and count it
    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        if (err_cnt < MAX_PRINTED)
            $display("mismatch on result %0d: %s got %0h expected %0h",
                     results_done, what, got, want);
        err_cnt++;
    endtask

    // Sample mix: full range, segment thresholds, rails, small and positive swings
    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        int v;
        case ($urandom_range(0, 5))
            0: v = $urandom_range(0, 65535) - 32768;
            1: v = $urandom_range(0, 10) * VOLT + $urandom_range(0, 2) - 1;
            2: v = $urandom_range(0, 1) ? 32767 : -32768;
            3: v = $urandom_range(0, 6000) - 3000;
            default: v = $urandom_range(0, 24000);
        endcase
        return SAMPLE_W'(v);
    endfunction

    task automatic add_tick(input logic signed [SAMPLE_W-1:0] l, input logic signed [SAMPLE_W-1:0] r,
                            input logic signed [SAMPLE_W-1:0] s1,
                            input logic signed [SAMPLE_W-1:0] s2, input logic b);
        tick_t t;
        t.left     = l;
        t.right    = r;
        t.send_one = s1;
        t.send_two = s2;
        t.button   = b;
        pending_ticks.push_back(t);
    endtask

    // APB write: setup cycle, access cycle, then release; mirror into the shadow
    task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] val);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(int'(idx) * 4);
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_GAIN:     gain_cfg     = val[GAIN_W-1:0];
            REG_SEG_HOLD: seg_hold_cfg = val[HOLD_W-1:0];
            REG_TOP_HOLD: top_hold_cfg = val[HOLD_W-1:0];
            default: ;
        endcase
    endtask

    // Wait until every queued tick has come back, then let the pipeline settle
    task automatic wait_drained(input int want);
        while (results_done != want)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Driver: present pending items, hold until taken, insert random gaps
    int tx_gap     = 0;
    bit tx_idle_on = 1'b1;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                expected_frames.push_back(gain_meter_step(on_wire));
            if (s_valid && !s_ready) begin
                // hold the current item
            end else if (tx_gap > 0) begin
                tx_gap--;
                s_valid <= 1'b0;
            end else if (pending_ticks.size() != 0) begin
                on_wire = pending_ticks.pop_front();
                s_valid           <= 1'b1;
                s_left_sample     <= on_wire.left;
                s_right_sample    <= on_wire.right;
                s_send_one_sample <= on_wire.send_one;
                s_send_two_sample <= on_wire.send_two;
                s_button_level    <= on_wire.button;
                if ($urandom_range(0, 29) == 0)
                    tx_idle_on = !tx_idle_on;
                tx_gap = tx_idle_on ? $urandom_range(0, 6) : 0;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Monitor: check each item against the oldest expectation, stall at random
    int rx_stall   = 0;
    int rx_pause   = 0;
    bit rx_idle_on = 1'b1;
    lamp_frame_t want;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                results_done++;
                if (expected_frames.size() == 0) begin
                    report("item with nothing expected", 32'd0, 32'd0);
                end else begin
                    want = expected_frames.pop_front();
                    if (m_left_out !== want.left_out)
                        report("left_out", 32'(m_left_out), 32'(want.left_out));
                    if (m_right_out !== want.right_out)
                        report("right_out", 32'(m_right_out), 32'(want.right_out));
                    if (m_send_one_out !== want.send_one_out)
                        report("send_one_out", 32'(m_send_one_out), 32'(want.send_one_out));
                    if (m_send_two_out !== want.send_two_out)
                        report("send_two_out", 32'(m_send_two_out), 32'(want.send_two_out));
                    if (m_on_lamp !== want.on_lamp)
                        report("on_lamp", 32'(m_on_lamp), 32'(want.on_lamp));
                    if (m_left_segments !== want.left_segs)
                        report("left_segments", 32'(m_left_segments), 32'(want.left_segs));
                    if (m_right_segments !== want.right_segs)
                        report("right_segments", 32'(m_right_segments), 32'(want.right_segs));
                end
                // long hold-off twice so the block backs up into its input
                if (results_done == 300 || results_done == 1000)
                    rx_pause = LONG_PAUSE;
                if ($urandom_range(0, 39) == 0)
                    rx_idle_on = !rx_idle_on;
                rx_stall = rx_idle_on ? $urandom_range(0, 6) : 0;
            end
            if (rx_pause > 0) begin
                rx_pause--;
                m_ready <= 1'b0;
            end else if (rx_stall > 0) begin
                rx_stall--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog: end the run if nothing moves for too long
    int quiet_cycles = 0;

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || psel)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Stimulus: reset, directed ticks, then phases of register settings and random ticks
    initial begin
        int total;
        bit btn;
        logic [DATA_W-1:0] g;
        logic [DATA_W-1:0] sh;
        logic [DATA_W-1:0] th;
        total = 0;
        btn   = 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // directed ticks at reset settings
        add_tick(16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0);
        add_tick(16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768, 1'b0);
        add_tick(-16'sd32768, 16'sd32767, -16'sd1, 16'sd0, 1'b0);
        add_tick(16'sd2048, 16'sd2049, 16'sh5555, 16'shAAAA, 1'b0);
        add_tick(16'sd20480, 16'sd20481, 16'shAAAA, 16'sh5555, 1'b0);
        add_tick(16'sd1, -16'sd1, 16'sd0, -16'sd1, 1'b0);
        add_tick(16'sd22527, 16'sd22528, 16'sd1, -16'sd2, 1'b0);
        // button press turns the output off, holding it does nothing more
        add_tick(16'sd30000, 16'sd30000, 16'sd100, 16'sd200, 1'b1);
        add_tick(16'sd30000, -16'sd30000, 16'sd300, 16'sd400, 1'b1);
        add_tick(16'sd4097, 16'sd4095, 16'sd500, 16'sd600, 1'b0);
        // second press turns it back on
        add_tick(16'sd4097, 16'sd4095, 16'sd700, 16'sd800, 1'b1);
        add_tick(16'sd18432, 16'sd18433, 16'sd900, 16'sd1000, 1'b0);
        add_tick(-16'sd2048, 16'sd10240, -16'sd1000, 16'sd32767, 1'b0);
        add_tick(16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0);
        add_tick(16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1);
        add_tick(16'sd32767, 16'sd32767, 16'sd0, 16'sd0, 1'b0);
        add_tick(16'sd32767, 16'sd32767, 16'sd0, 16'sd0, 1'b1);
        add_tick(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, 1'b0);
        total += pending_ticks.size();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            wait_drained(total);
            // fixed settings first, extremes among them, random short holds afterward
            case (ph)
                0: begin g = 1023; sh = 0;     th = 32767; end
                1: begin g = 0;    sh = 5;     th = 5;     end
                2: begin g = 700;  sh = 32767; th = 0;     end
                3: begin g = 512;  sh = 3;     th = 9;     end
                4: begin g = 256;  sh = 1;     th = 2;     end
                default: begin
                    g  = $urandom_range(0, 1023);
                    sh = $urandom_range(0, 12);
                    th = $urandom_range(0, 40);
                end
            endcase
            write_reg(REG_GAIN, g);
            write_reg(REG_SEG_HOLD, sh);
            write_reg(REG_TOP_HOLD, th);
            for (int k = 0; k < TICKS_PER_PHASE; k++) begin
                if ($urandom_range(0, 9) == 0)
                    btn = !btn;
                add_tick(pick_sample(), pick_sample(), SAMPLE_W'($urandom),
                         SAMPLE_W'($urandom), btn);
            end
            total += TICKS_PER_PHASE;
        end

        wait_drained(total);
        if (expected_frames.size() != 0)
            report("expectations left over", expected_frames.size(), 32'd0);
        if (err_cnt == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule

[stereo_gain_bar_meter_hold.f]
+incdir+rtl
rtl/sgbm_pkg.sv
rtl/sgbm_gain_lane.sv
rtl/sgbm_meter_lane.sv
rtl/stereo_gain_bar_meter_hold.sv
verif/tb_stereo_gain_bar_meter_hold.sv
